FILE: hw/rtl/fwpd_pkg.sv
// Package for the four-wheel incremental PD speed controller.
// Holds the item and result payload types, register index codes and fixed constants.
// Depends on nothing; used by four_wheel_incremental_pd_speed.
package fwpd_pkg;

  localparam int WHEEL_COUNT_DEFAULT = 4;
  localparam int DRIVE_BITS_DEFAULT  = 11;

  // Wheels that have fields of their own in the item and the result.
  localparam int FIELD_WHEELS     = 4;
  localparam int COUNT_BITS       = 10;
  localparam int DRIVE_FIELD_BITS = 11;
  localparam int SPEED_BITS       = 10;
  localparam int GAIN_BITS        = 10;
  localparam int WORD_BITS        = 32;
  localparam int OFFSET_BITS      = 8;
  localparam int ERR_BITS         = 7;

  localparam int ERR_LIMIT        = 50;
  localparam int FIXED_DRIVE      = 60;
  localparam int BASE_THRESHOLD   = 60;
  localparam int LOW_BASE_MARGIN  = 60;
  localparam int HI_MARGIN        = 200;
  localparam int HI_MARGIN_WHEEL1 = 150;

  localparam logic [GAIN_BITS-1:0] PROP_GAIN_RESET  = 10'd154;
  localparam logic [GAIN_BITS-1:0] DERIV_GAIN_RESET = 10'd128;

  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_SPEED     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_OFFSETS = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PROP_GAIN      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DERIV_GAIN     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DISTANCE_LIMIT = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_ENABLE    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIXED_MODE     = 3'd6;

  typedef struct packed {
    logic                  restart;
    logic [COUNT_BITS-1:0] wheel0_count;
    logic [COUNT_BITS-1:0] wheel1_count;
    logic [COUNT_BITS-1:0] wheel2_count;
    logic [COUNT_BITS-1:0] wheel3_count;
  } item_t;

  typedef struct packed {
    logic [DRIVE_FIELD_BITS-1:0] drive0;
    logic [DRIVE_FIELD_BITS-1:0] drive1;
    logic [DRIVE_FIELD_BITS-1:0] drive2;
    logic [DRIVE_FIELD_BITS-1:0] drive3;
    logic                        stop_request;
  } result_t;

endpackage

FILE: hw/rtl/four_wheel_incremental_pd_speed.sv
// Top level of the four-wheel incremental PD speed controller.
// Item register, per-wheel PD and clamp lanes, distance tracking and result register.
// Depends on fwpd_pkg for payload types, register codes and constants.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+------------------------------
//   item     | in        | item_valid / item_stall  | item (restart, four counts)
//   result   | out       | result_valid / result_stall | result (four drives, stop)
//   cfg      | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// An item is captured in the item register, then combinational lane logic loads the result
// register; a stalled result holds the item in the item register. One item per cycle is
// sustained while the result is not stalled. The controller state updates as an item moves
// into the result register.
// A stalled result holds, and the item register takes a transfer while it is empty or the
// result register is free or being emptied. Synchronous reset sets the controller state,
// configuration and valid flags to their reset values; configuration writes are always accepted.
module four_wheel_incremental_pd_speed #(
  parameter int WHEEL_COUNT = fwpd_pkg::WHEEL_COUNT_DEFAULT,
  parameter int DRIVE_BITS  = fwpd_pkg::DRIVE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  fwpd_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output fwpd_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fwpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [fwpd_pkg::WORD_BITS-1:0]      cfg_data
);

  localparam int SW = ((DRIVE_BITS > fwpd_pkg::DRIVE_FIELD_BITS) ? DRIVE_BITS
                       : fwpd_pkg::DRIVE_FIELD_BITS) + 2;
  localparam int DRIVE_MAX_INT = (1 << DRIVE_BITS) - 1;
  localparam int FW = fwpd_pkg::FIELD_WHEELS;
  localparam int CB = fwpd_pkg::COUNT_BITS;
  localparam int EB = fwpd_pkg::ERR_BITS;
  localparam int DFB = fwpd_pkg::DRIVE_FIELD_BITS;

  // Configuration registers.
  logic [fwpd_pkg::SPEED_BITS-1:0] base_speed;
  logic [fwpd_pkg::WORD_BITS-1:0]  wheel_target_offsets;
  logic [fwpd_pkg::GAIN_BITS-1:0]  prop_gain;
  logic [fwpd_pkg::GAIN_BITS-1:0]  deriv_gain;
  logic [fwpd_pkg::WORD_BITS-1:0]  distance_limit;
  logic                            distance_stop_enable;
  logic                            fixed_output_mode;

  // Controller state.
  logic [DRIVE_BITS-1:0]          previous_drive [WHEEL_COUNT];
  logic signed [EB-1:0]           previous_error [WHEEL_COUNT];
  logic [fwpd_pkg::WORD_BITS-1:0] distance_total;
  logic                           distance_armed;

  // Pipeline registers.
  fwpd_pkg::item_t stage_item;
  logic            stage_valid;

  logic out_free;
  logic advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed           <= '0;
      wheel_target_offsets <= '0;
      prop_gain            <= fwpd_pkg::PROP_GAIN_RESET;
      deriv_gain           <= fwpd_pkg::DERIV_GAIN_RESET;
      distance_limit       <= '0;
      distance_stop_enable <= 1'b0;
      fixed_output_mode    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fwpd_pkg::REG_BASE_SPEED:     base_speed <= cfg_data[fwpd_pkg::SPEED_BITS-1:0];
        fwpd_pkg::REG_TARGET_OFFSETS: wheel_target_offsets <= cfg_data;
        fwpd_pkg::REG_PROP_GAIN:      prop_gain <= cfg_data[fwpd_pkg::GAIN_BITS-1:0];
        fwpd_pkg::REG_DERIV_GAIN:     deriv_gain <= cfg_data[fwpd_pkg::GAIN_BITS-1:0];
        fwpd_pkg::REG_DISTANCE_LIMIT: distance_limit <= cfg_data;
        fwpd_pkg::REG_STOP_ENABLE:    distance_stop_enable <= cfg_data[0];
        fwpd_pkg::REG_FIXED_MODE:     fixed_output_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register can load when it is empty or being emptied.
  assign out_free   = !result_valid || !result_stall;
  assign advance    = stage_valid && out_free;
  assign item_stall = stage_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage_item <= item;
    end
  end

  // Clamp window for the lanes; wheel 1 has its own high limit when the base is above the
  // threshold. The low limit is base/5, exact for a 10-bit base as (base * 205) >> 10.
  logic                   base_high;
  logic [DFB-1:0]         hi_main;
  logic [DFB-1:0]         hi_wheel1;
  logic [19:0]            lo_product;
  logic [7:0]             lo_limit;

  always_comb begin
    base_high  = base_speed > fwpd_pkg::SPEED_BITS'(fwpd_pkg::BASE_THRESHOLD);
    hi_main    = base_high ? (DFB'(base_speed) + DFB'(fwpd_pkg::HI_MARGIN))
                           : (DFB'(base_speed) + DFB'(fwpd_pkg::LOW_BASE_MARGIN));
    hi_wheel1  = base_high ? (DFB'(base_speed) + DFB'(fwpd_pkg::HI_MARGIN_WHEEL1))
                           : hi_main;
    lo_product = 20'(base_speed) * 20'd205;
    lo_limit   = lo_product[17:10];
  end

  logic [CB-1:0] field_count [FW];
  assign field_count[0] = stage_item.wheel0_count;
  assign field_count[1] = stage_item.wheel1_count;
  assign field_count[2] = stage_item.wheel2_count;
  assign field_count[3] = stage_item.wheel3_count;

  logic [DRIVE_BITS-1:0]  lane_drive [WHEEL_COUNT];
  logic signed [EB-1:0]   lane_error [WHEEL_COUNT];
  logic [DFB-1:0]         lane_field [WHEEL_COUNT];

  for (genvar p = 0; p < WHEEL_COUNT; p++) begin : g_lane
    logic [CB-1:0]          cnt;
    logic [7:0]             offset;
    logic [DFB-1:0]         hi_limit;
    logic signed [12:0]     err_raw;
    logic signed [EB-1:0]   err;
    logic signed [17:0]     prod_p;
    logic signed [17:0]     bias_p;
    logic signed [9:0]      term_p;
    logic signed [7:0]      err_delta;
    logic signed [18:0]     prod_d;
    logic signed [18:0]     bias_d;
    logic signed [9:0]      term_d;
    logic signed [SW-1:0]   sum;
    logic signed [SW-1:0]   hi_ext;
    logic signed [SW-1:0]   lo_ext;
    logic signed [SW-1:0]   clamp_hi;
    logic signed [SW-1:0]   clamp_lo;
    logic signed [SW-1:0]   clamp_sat;

    // Lanes without item fields see a count of zero and no offset.
    if (p < FW) begin : g_field
      assign cnt    = field_count[p];
      assign offset = wheel_target_offsets[8*p +: 8];
    end else begin : g_extra
      assign cnt    = '0;
      assign offset = '0;
    end

    if (p == 1) begin : g_hi1
      assign hi_limit = hi_wheel1;
    end else begin : g_hi
      assign hi_limit = hi_main;
    end

    always_comb begin
      err_raw = $signed({3'b000, base_speed}) + $signed({{5{offset[7]}}, offset})
              - $signed({3'b000, cnt});
      if (err_raw > 13'sd50) begin
        err = EB'(fwpd_pkg::ERR_LIMIT);
      end else if (err_raw < -13'sd50) begin
        err = -EB'(fwpd_pkg::ERR_LIMIT);
      end else begin
        err = err_raw[EB-1:0];
      end

      // Division by 256 rounding toward zero: bias negative products first.
      prod_p = $signed({8'd0, prop_gain}) * $signed({{11{err[EB-1]}}, err});
      bias_p = prod_p + (prod_p[17] ? 18'sd255 : 18'sd0);
      term_p = bias_p[17:8];

      err_delta = $signed({previous_error[p][EB-1], previous_error[p]})
                - $signed({err[EB-1], err});
      prod_d = $signed({9'd0, deriv_gain}) * $signed({{11{err_delta[7]}}, err_delta});
      bias_d = prod_d + (prod_d[18] ? 19'sd255 : 19'sd0);
      term_d = bias_d[17:8];

      sum = $signed({{(SW-DRIVE_BITS){1'b0}}, previous_drive[p]})
          + $signed({{(SW-10){term_p[9]}}, term_p})
          + $signed({{(SW-10){term_d[9]}}, term_d});

      hi_ext = $signed({{(SW-DFB){1'b0}}, hi_limit});
      lo_ext = $signed({{(SW-8){1'b0}}, lo_limit});

      // A negative sum falls below the low limit and takes it.
      clamp_hi  = (sum > hi_ext) ? hi_ext : sum;
      clamp_lo  = (clamp_hi < lo_ext) ? lo_ext : clamp_hi;
      clamp_sat = (clamp_lo > $signed(SW'(DRIVE_MAX_INT))) ? $signed(SW'(DRIVE_MAX_INT))
                                                          : clamp_lo;
    end

    assign lane_drive[p] = clamp_sat[DRIVE_BITS-1:0];
    assign lane_error[p] = err;
    assign lane_field[p] = clamp_sat[DFB-1:0];
  end

  // Result drive fields; wheels beyond the lane count read zero.
  logic [DFB-1:0] field_drive [FW];

  for (genvar p = 0; p < FW; p++) begin : g_out
    if (p < WHEEL_COUNT) begin : g_used
      assign field_drive[p] = fixed_output_mode ? DFB'(fwpd_pkg::FIXED_DRIVE)
                            : (stage_item.restart ? '0 : lane_field[p]);
    end else begin : g_unused
      assign field_drive[p] = '0;
    end
  end

  // The distance is updated before the limit is compared.
  logic [fwpd_pkg::WORD_BITS-1:0] distance_sum;
  logic                           stop_fire;

  always_comb begin
    distance_sum = distance_total + fwpd_pkg::WORD_BITS'(stage_item.wheel3_count);
    stop_fire    = distance_armed && (distance_sum > distance_limit) && !stage_item.restart;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WHEEL_COUNT; k++) begin
        previous_drive[k] <= '0;
        previous_error[k] <= '0;
      end
      distance_total <= '0;
      distance_armed <= 1'b0;
    end else if (advance) begin
      if (stage_item.restart) begin
        for (int k = 0; k < WHEEL_COUNT; k++) begin
          previous_drive[k] <= '0;
          previous_error[k] <= '0;
        end
        distance_total <= '0;
        distance_armed <= distance_stop_enable;
      end else begin
        for (int k = 0; k < WHEEL_COUNT; k++) begin
          previous_drive[k] <= lane_drive[k];
          previous_error[k] <= lane_error[k];
        end
        distance_total <= distance_sum;
        if (stop_fire) begin
          distance_armed <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.drive0       <= field_drive[0];
      result.drive1       <= field_drive[1];
      result.drive2       <= field_drive[2];
      result.drive3       <= field_drive[3];
      result.stop_request <= stop_fire;
    end
  end

endmodule
